### rtl/bitmap_line_and_square_search_unit_defines.svh
`ifndef BITMAP_LINE_AND_SQUARE_SEARCH_UNIT_DEFINES_SVH
`define BITMAP_LINE_AND_SQUARE_SEARCH_UNIT_DEFINES_SVH

// checked out of reset only
`define BLSS_CHK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked in reset as well
`define BLSS_CHK_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/blss_pkg.sv
package blss_pkg;

	localparam int MAX_DIM_DEF = 64;
	localparam int PAW = 4;

	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;
	localparam logic [1:0] REG_MODE = 2'd2;

	localparam logic [1:0] MODE_HORZ = 2'd0;
	localparam logic [1:0] MODE_VERT = 2'd1;
	localparam logic [1:0] MODE_SQR  = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic [6:0] ROWS_RST = 7'd2;
	localparam logic [6:0] COLS_RST = 7'd2;

	typedef struct packed {
		logic pixel;
		logic last_pixel;
	} in_word_t;

	typedef struct packed {
		logic       found;
		logic [5:0] start_row;
		logic [5:0] start_col;
		logic [5:0] end_row;
		logic [5:0] end_col;
	} out_word_t;

	typedef struct packed {
		logic [6:0] row_count;
		logic [6:0] col_count;
		logic [1:0] search_mode;
	} cfg_t;

endpackage

### rtl/blss_cfg.sv
module blss_cfg import blss_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [PAW-1:0] paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	output cfg_t           cfg
);

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count   <= ROWS_RST;
			cfg_q.col_count   <= COLS_RST;
			cfg_q.search_mode <= MODE_HORZ;
		end else if (wr) begin
			case (paddr[PAW-1:2])
				REG_ROWS: cfg_q.row_count   <= pwdata[6:0];
				REG_COLS: cfg_q.col_count   <= pwdata[6:0];
				REG_MODE: cfg_q.search_mode <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[PAW-1:2])
			REG_ROWS: prdata = {25'd0, cfg_q.row_count};
			REG_COLS: prdata = {25'd0, cfg_q.col_count};
			REG_MODE: prdata = {30'd0, cfg_q.search_mode};
			default:  prdata = 32'd0;
		endcase
	end

endmodule

### rtl/bitmap_line_and_square_search_unit.sv
// Load: one pixel word per cycle into the bitmap RAM while idle, no result.
// On the last pixel: run-length prepass (read, write per cell), then a scan (read,
// evaluate per cell), plus a read and evaluate per square edge check in square mode;
// result registered. Input stalled until the result is registered.
// Reset clears control, configuration and the pending result; bitmap RAM is undefined.
module bitmap_line_and_square_search_unit import blss_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pix_valid,
	output logic           pix_stall,
	input  in_word_t       pix_word,
	output logic           res_valid,
	input  logic           res_stall,
	output out_word_t      res_word,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [PAW-1:0] paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int AW = $clog2(CELLS);
	localparam int LW = $clog2(CELLS + 1);
	localparam int CW = $clog2(MAX_DIM);
	localparam int DW = $clog2(MAX_DIM + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_PRE_RD = 4'd1;
	localparam logic [3:0] ST_PRE_WR = 4'd2;
	localparam logic [3:0] ST_SCN_RD = 4'd3;
	localparam logic [3:0] ST_SCN_EV = 4'd4;
	localparam logic [3:0] ST_CHK_RD = 4'd5;
	localparam logic [3:0] ST_CHK_EV = 4'd6;
	localparam logic [3:0] ST_FIN    = 4'd7;

	cfg_t cfg;

	blss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [3:0]    state_q;
	logic [CW-1:0] r_q, c_q;
	logic [LW-1:0] load_q;
	logic [DW-1:0] best_q, rrun_q, side_q, lim_q;
	logic [CW-1:0] b_sr_q, b_sc_q, b_er_q, b_ec_q;
	logic          res_valid_q;
	out_word_t     res_word_q;

	logic          bmp_mem [CELLS];
	logic [2*DW-1:0] run_mem [CELLS];
	logic          bmp_rd_q;
	logic [2*DW-1:0] runa_q, runb_q;

	logic [DW-1:0] rows_used, cols_used;
	logic [AW-1:0] idx_rc, idx_i, idx_j, addr_a;
	logic [CW-1:0] i_row, j_col;
	logic          r_last, c_last;
	logic [CW-1:0] rm_r, rm_c, cm_r, cm_c;
	logic          rm_done, cm_done;
	logic [DW-1:0] ra, da, db, r_new, d_new, sq_lim;
	logic          pix_acc, bmp_we, run_we;

	assign rows_used = (int'(cfg.row_count) > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg.row_count);
	assign cols_used = (int'(cfg.col_count) > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg.col_count);

	assign i_row  = CW'(DW'(r_q) + side_q - DW'(1));
	assign j_col  = CW'(DW'(c_q) + side_q - DW'(1));
	assign idx_rc = AW'(r_q) * AW'(cols_used) + AW'(c_q);
	assign idx_i  = AW'(i_row) * AW'(cols_used) + AW'(c_q);
	assign idx_j  = AW'(r_q) * AW'(cols_used) + AW'(j_col);

	assign r_last = (DW'(r_q) + DW'(1)) == rows_used;
	assign c_last = (DW'(c_q) + DW'(1)) == cols_used;

	// next cell, row-major and column-major
	always_comb begin
		rm_r = r_q;
		rm_c = c_q + CW'(1);
		rm_done = 1'b0;
		if (c_last) begin
			rm_c = '0;
			rm_r = r_q + CW'(1);
			rm_done = r_last;
		end
		cm_c = c_q;
		cm_r = r_q + CW'(1);
		cm_done = 1'b0;
		if (r_last) begin
			cm_r = '0;
			cm_c = c_q + CW'(1);
			cm_done = c_last;
		end
	end

	assign ra = runa_q[2*DW-1:DW];
	assign da = runa_q[DW-1:0];
	assign db = runb_q[DW-1:0];
	assign sq_lim = (ra < da) ? ra : da;

	assign r_new = !bmp_rd_q ? '0 : (c_last ? DW'(1) : rrun_q + DW'(1));
	assign d_new = !bmp_rd_q ? '0 : (r_last ? DW'(1) : da + DW'(1));

	assign pix_stall = (state_q != ST_IDLE);
	assign pix_acc   = pix_valid && !pix_stall;
	assign bmp_we    = pix_acc && (load_q < LW'(CELLS));
	assign run_we    = (state_q == ST_PRE_WR);

	always_comb begin
		case (state_q)
			ST_PRE_RD: addr_a = idx_rc + AW'(cols_used);
			ST_CHK_RD: addr_a = idx_i;
			default:   addr_a = idx_rc;
		endcase
	end

	always_ff @(posedge clk) begin
		if (bmp_we) begin
			bmp_mem[AW'(load_q)] <= pix_word.pixel;
		end
		bmp_rd_q <= bmp_mem[idx_rc];
	end

	always_ff @(posedge clk) begin
		if (run_we) begin
			run_mem[idx_rc] <= {r_new, d_new};
		end
		runa_q <= run_mem[addr_a];
		runb_q <= run_mem[idx_j];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			load_q      <= '0;
			r_q         <= '0;
			c_q         <= '0;
			best_q      <= '0;
			rrun_q      <= '0;
			side_q      <= '0;
			lim_q       <= '0;
			b_sr_q      <= '0;
			b_sc_q      <= '0;
			b_er_q      <= '0;
			b_ec_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pix_acc) begin
						if (bmp_we) begin
							load_q <= load_q + LW'(1);
						end
						if (pix_word.last_pixel) begin
							load_q <= '0;
							best_q <= '0;
							b_sr_q <= '0;
							b_sc_q <= '0;
							b_er_q <= '0;
							b_ec_q <= '0;
							r_q    <= CW'(rows_used - DW'(1));
							c_q    <= CW'(cols_used - DW'(1));
							if (cfg.search_mode == MODE_NONE || rows_used == '0 ||
									cols_used == '0) begin
								state_q <= ST_FIN;
							end else begin
								state_q <= ST_PRE_RD;
							end
						end
					end
				end
				ST_PRE_RD: state_q <= ST_PRE_WR;
				ST_PRE_WR: begin
					rrun_q  <= r_new;
					state_q <= ST_PRE_RD;
					if (c_q == '0) begin
						c_q <= CW'(cols_used - DW'(1));
						if (r_q == '0) begin
							c_q     <= '0;
							state_q <= ST_SCN_RD;
						end else begin
							r_q <= r_q - CW'(1);
						end
					end else begin
						c_q <= c_q - CW'(1);
					end
				end
				ST_SCN_RD: state_q <= ST_SCN_EV;
				ST_SCN_EV: begin
					case (cfg.search_mode)
						MODE_HORZ: begin
							if (ra > best_q) begin
								best_q <= ra;
								b_sr_q <= r_q;
								b_sc_q <= c_q;
								b_er_q <= r_q;
								b_ec_q <= CW'(DW'(c_q) + ra - DW'(1));
							end
							r_q <= rm_r;
							c_q <= rm_c;
							state_q <= rm_done ? ST_FIN : ST_SCN_RD;
						end
						MODE_VERT: begin
							if (da > best_q) begin
								best_q <= da;
								b_sr_q <= r_q;
								b_sc_q <= c_q;
								b_er_q <= CW'(DW'(r_q) + da - DW'(1));
								b_ec_q <= c_q;
							end
							r_q <= cm_r;
							c_q <= cm_c;
							state_q <= cm_done ? ST_FIN : ST_SCN_RD;
						end
						default: begin
							if (ra >= DW'(2) && sq_lim > best_q) begin
								side_q  <= (best_q < DW'(2)) ? DW'(2) : best_q + DW'(1);
								lim_q   <= sq_lim;
								state_q <= ST_CHK_RD;
							end else begin
								r_q <= cm_r;
								c_q <= cm_c;
								state_q <= cm_done ? ST_FIN : ST_SCN_RD;
							end
						end
					endcase
				end
				ST_CHK_RD: state_q <= ST_CHK_EV;
				ST_CHK_EV: begin
					if (ra >= side_q && db >= side_q) begin
						best_q <= side_q;
						b_sr_q <= r_q;
						b_sc_q <= c_q;
						b_er_q <= i_row;
						b_ec_q <= j_col;
					end
					if (side_q == lim_q) begin
						r_q <= cm_r;
						c_q <= cm_c;
						state_q <= cm_done ? ST_FIN : ST_SCN_RD;
					end else begin
						side_q  <= side_q + DW'(1);
						state_q <= ST_CHK_RD;
					end
				end
				ST_FIN: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!res_valid_q || !res_stall)) begin
			res_word_q.found     <= best_q >= DW'(2);
			res_word_q.start_row <= (best_q >= DW'(2)) ? 6'(b_sr_q) : 6'd0;
			res_word_q.start_col <= (best_q >= DW'(2)) ? 6'(b_sc_q) : 6'd0;
			res_word_q.end_row   <= (best_q >= DW'(2)) ? 6'(b_er_q) : 6'd0;
			res_word_q.end_col   <= (best_q >= DW'(2)) ? 6'(b_ec_q) : 6'd0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule

### rtl/blss_checker.sv
`include "bitmap_line_and_square_search_unit_defines.svh"

module blss_checker import blss_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_stall,
	input out_word_t res_word
);

	`BLSS_CHK(res_hold, res_valid && res_stall |=> res_valid && $stable(res_word), "word dropped")
	`BLSS_CHK(miss_zero, res_valid && !res_word.found |-> res_word.start_row == 6'd0 &&
		res_word.start_col == 6'd0 && res_word.end_row == 6'd0 && res_word.end_col == 6'd0,
		"miss not zeroed")
	`BLSS_CHK(hit_order, res_valid && res_word.found |-> res_word.start_row <= res_word.end_row &&
		res_word.start_col <= res_word.end_col, "corners out of order")
	`BLSS_CHK_RST(rst_quiet, !arst_n |-> !res_valid, "word in reset")

endmodule

bind bitmap_line_and_square_search_unit blss_checker u_blss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_word  (res_word)
);

### tb/tb_bitmap_line_and_square_search_unit.sv
module tb_bitmap_line_and_square_search_unit;
	import blss_pkg::*;

	localparam int DIM = 64;
	localparam int CELLS = DIM * DIM;
	localparam int STALL_LIMIT = 200000;

	logic           clk;
	logic           arst_n;
	logic           pix_valid;
	logic           pix_stall;
	in_word_t       pix_word;
	logic           res_valid;
	logic           res_stall;
	out_word_t      res_word;
	logic           psel;
	logic           penable;
	logic           pwrite;
	logic [PAW-1:0] paddr;
	logic [31:0]    pwdata;
	logic [31:0]    prdata;
	logic           pready;

	bitmap_line_and_square_search_unit dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix_word(pix_word),
		.res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	bit         bmp [CELLS];
	int         load_pos;
	logic [6:0] rows_reg;
	logic [6:0] cols_reg;
	logic [1:0] mode_reg;
	int         rows_in_use;
	int         cols_in_use;

	out_word_t  result_queue [$];
	int         errors;
	int         idle_cycles;
	bit         timed_out;
	bit         pix_held;

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = 1'b1;
			#5 clk = 1'b0;
		end
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	function automatic bit px_at(int r, int c);
		int idx;
		if (r >= rows_in_use || c >= cols_in_use)
			return 1'b0;
		idx = r * cols_in_use + c;
		if (idx >= CELLS)
			return 1'b0;
		return bmp[idx];
	endfunction

	function automatic int ones_right(int r, int c);
		int n;
		n = 0;
		while (px_at(r, c + n))
			n++;
		return n;
	endfunction

	function automatic int ones_down(int r, int c);
		int n;
		n = 0;
		while (px_at(r + n, c))
			n++;
		return n;
	endfunction

	function automatic out_word_t find_shape();
		out_word_t res;
		int best;
		int n;
		int top;
		int side;
		int i;
		res = '0;
		best = 0;
		rows_in_use = (rows_reg > DIM) ? DIM : rows_reg;
		cols_in_use = (cols_reg > DIM) ? DIM : cols_reg;
		if (mode_reg == MODE_HORZ) begin
			for (int r = 0; r < rows_in_use; r++)
				for (int c = 0; c < cols_in_use; c++) begin
					n = ones_right(r, c);
					if (n > best) begin
						best = n;
						res = {1'b1, 6'(r), 6'(c), 6'(r), 6'(c + n - 1)};
					end
				end
		end else if (mode_reg == MODE_VERT) begin
			for (int c = 0; c < cols_in_use; c++)
				for (int r = 0; r < rows_in_use; r++) begin
					n = ones_down(r, c);
					if (n > best) begin
						best = n;
						res = {1'b1, 6'(r), 6'(c), 6'(r + n - 1), 6'(c)};
					end
				end
		end else if (mode_reg == MODE_SQR) begin
			for (int c = 0; c < cols_in_use; c++)
				for (int r = 0; r < rows_in_use; r++) begin
					top = ones_right(r, c);
					if (top < 2)
						continue;
					for (i = r + 1; px_at(i, c); i++) begin
						side = i - r + 1;
						if (top >= side && ones_right(i, c) >= side &&
								ones_down(r, c + side - 1) >= side && side > best) begin
							best = side;
							res = {1'b1, 6'(r), 6'(c), 6'(i), 6'(c + side - 1)};
						end
					end
				end
		end
		if (best < 2)
			res = '0;
		return res;
	endfunction

	task automatic drop_valid();
		if (pix_held) begin
			pix_valid <= 1'b0;
			pix_held = 1'b0;
		end
	endtask

	task automatic idle_on_pix();
		int n;
		n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		if (n > 0)
			drop_valid();
		repeat (n) @(posedge clk);
	endtask

	task automatic send_pixel(input bit px, input bit last);
		in_word_t w;
		if ($urandom_range(0, 1))
			idle_on_pix();
		w.pixel = px;
		w.last_pixel = last;
		pix_valid <= 1'b1;
		pix_held = 1'b1;
		pix_word <= w;
		do @(posedge clk); while (pix_stall);
		if (load_pos < CELLS) begin
			bmp[load_pos] = px;
			load_pos++;
		end
		if (last) begin
			result_queue.push_back(find_shape());
			load_pos = 0;
		end
	endtask

	task automatic wait_drained();
		drop_valid();
		while (result_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		wait_drained();
		repeat (20) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PAW'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_ROWS)
			rows_reg = val[6:0];
		else if (idx == REG_COLS)
			cols_reg = val[6:0];
		else if (idx == REG_MODE)
			mode_reg = val[1:0];
	endtask

	task automatic set_shape(input int r, input int c, input logic [1:0] m);
		write_reg(REG_ROWS, 32'(r));
		write_reg(REG_COLS, 32'(c));
		write_reg(REG_MODE, 32'(m));
	endtask

	// n pixels, density in percent
	task automatic send_bitmap(input int n, input int density);
		for (int k = 0; k < n; k++)
			send_pixel($urandom_range(1, 100) <= density, k == n - 1);
	endtask

	function automatic int cells_used();
		int r;
		int c;
		r = (rows_reg > DIM) ? DIM : rows_reg;
		c = (cols_reg > DIM) ? DIM : cols_reg;
		return r * c;
	endfunction

	task automatic test_directed();
		// all set, all clear, each mode on a 2x2 bitmap
		for (int m = 0; m < 4; m++) begin
			set_shape(2, 2, 2'(m));
			send_bitmap(4, 100);
			send_bitmap(4, 0);
		end
		// lone pixel gives nothing
		set_shape(2, 3, MODE_HORZ);
		for (int k = 0; k < 6; k++)
			send_pixel(k == 4, k == 5);
	endtask

	task automatic test_clipped();
		// oversize settings clip to the full height or width
		set_shape(127, 2, MODE_VERT);
		send_bitmap(2 * DIM, 90);
		write_reg(REG_MODE, 32'(MODE_SQR));
		send_bitmap(2 * DIM, 95);
		set_shape(2, 127, MODE_HORZ);
		send_bitmap(2 * DIM, 90);
		write_reg(REG_MODE, 32'(MODE_SQR));
		send_bitmap(2 * DIM, 95);
	endtask

	task automatic test_odd_sizes();
		// short load keeps older contents; dimension one and zero
		set_shape(5, 5, MODE_SQR);
		send_bitmap(10, 80);
		set_shape(1, 8, MODE_HORZ);
		send_bitmap(8, 70);
		set_shape(0, 8, MODE_VERT);
		send_bitmap(8, 70);
	endtask

	task automatic test_random(input int items);
		int sent;
		int n;
		sent = 0;
		while (sent < items) begin
			set_shape($urandom_range(2, 9), $urandom_range(2, 9), 2'($urandom_range(0, 3)));
			for (int b = 0; b < 4; b++) begin
				n = cells_used();
				if ($urandom_range(0, 9) == 0 && n > 2)
					n = $urandom_range(1, n - 1);
				send_bitmap(n, $urandom_range(30, 95));
				sent += n;
			end
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
	endtask

	initial begin
		idle_cycles = 0;
		timed_out = 1'b0;
		forever begin
			@(posedge clk);
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("** bitmap_line_and_square_search_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		out_word_t exp_w;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall) begin
				if (result_queue.size() == 0) begin
					report("result with none expected");
				end else begin
					exp_w = result_queue.pop_front();
					if (res_word.found !== exp_w.found)
						report($sformatf("found %0b exp %0b", res_word.found, exp_w.found));
					if (res_word.start_row !== exp_w.start_row)
						report($sformatf("start_row %0d exp %0d", res_word.start_row,
							exp_w.start_row));
					if (res_word.start_col !== exp_w.start_col)
						report($sformatf("start_col %0d exp %0d", res_word.start_col,
							exp_w.start_col));
					if (res_word.end_row !== exp_w.end_row)
						report($sformatf("end_row %0d exp %0d", res_word.end_row,
							exp_w.end_row));
					if (res_word.end_col !== exp_w.end_col)
						report($sformatf("end_col %0d exp %0d", res_word.end_col,
							exp_w.end_col));
				end
			end
		end
	end

	// receiver stall pattern, with quiet stretches
	initial begin
		int n;
		res_stall = 1'b1;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
				if (n > 0)
					res_stall <= 1'b1;
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
			end else if (res_stall && arst_n) begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		errors = 0;
		load_pos = 0;
		pix_held = 1'b0;
		rows_reg = ROWS_RST;
		cols_reg = COLS_RST;
		mode_reg = MODE_HORZ;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix_word = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_clipped();
		test_odd_sizes();
		test_random(900);
		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("** bitmap_line_and_square_search_unit: PASSED **");
		else
			$display("** bitmap_line_and_square_search_unit: FAILED **");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/blss_pkg.sv
rtl/blss_cfg.sv
rtl/bitmap_line_and_square_search_unit.sv
rtl/blss_checker.sv
tb/tb_bitmap_line_and_square_search_unit.sv
